/* design/mfi_pkg.sv */
// ----------------------------------------------------------------------------
// mfi_pkg: shared types and constants for mesh face index lookup
// Effective-count widths, region and shape codes, pipeline stage payloads.
// ----------------------------------------------------------------------------
package mfi_pkg;

    localparam int MAX_SEGMENTS  = 256;
    localparam int FRACTION_BITS = 16;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int SHAPE_W   = 3;
    localparam int REGION_W  = 3;
    localparam int FACE_W    = 18;

    // effective count holds 1..MAX_SEGMENTS
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    // row term reaches hs + h + floor(v*hs), below 2*MAX_SEGMENTS
    localparam int ROW_W = $clog2(2 * MAX_SEGMENTS + 1);

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_CYLINDER = 3'd0,
        SHAPE_SPHERE   = 3'd1,
        SHAPE_CAPSULE  = 3'd2,
        SHAPE_CONE     = 3'd3,
        SHAPE_TORUS    = 3'd4
    } t_shape;

    localparam logic [REGION_W-1:0] REGION_TOP        = 3'd0;
    localparam logic [REGION_W-1:0] REGION_BOTTOM     = 3'd1;
    localparam logic [REGION_W-1:0] REGION_BASE       = 3'd2;
    localparam logic [REGION_W-1:0] REGION_SIDE       = 3'd3;
    localparam logic [REGION_W-1:0] REGION_TOP_CAP    = 3'd4;
    localparam logic [REGION_W-1:0] REGION_BOTTOM_CAP = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AROUND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TUBE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONGITUDE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LATITUDE  = 3'd6;

    typedef enum logic [1:0] {
        ROW_NONE = 2'd0,
        ROW_U    = 2'd1,
        ROW_V    = 2'd2
    } t_row_src;

    typedef enum logic [1:0] {
        COL_U     = 2'd0,
        COL_V     = 2'd1,
        COL_CONST = 2'd2
    } t_col_src;

    typedef struct packed {
        logic [SHAPE_W-1:0] shape;
        logic [CNT_W-1:0]   around;
        logic [CNT_W-1:0]   height;
        logic [CNT_W-1:0]   ring;
        logic [CNT_W-1:0]   tube;
        logic [CNT_W-1:0]   longitude;
        logic [CNT_W-1:0]   latitude;
    } t_cfg_eff;

    // face = (row_base + row cell) * stride + column term
    typedef struct packed {
        logic [CNT_W-1:0] cell_u;
        logic [CNT_W-1:0] cell_v;
        logic [ROW_W-1:0] row_base;
        t_row_src         row_src;
        t_col_src         col_src;
        logic [CNT_W-1:0] col_const;
        logic [CNT_W-1:0] stride;
    } t_s2;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] stride;
    } t_s3;

    // zero reads as one, oversize reads as MAX_SEGMENTS
    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] c);
        logic [CNT_W-1:0] res;
        if (c == '0) begin
            res = CNT_W'(1);
        end else if (int'(c) > MAX_SEGMENTS) begin
            res = CNT_W'(MAX_SEGMENTS);
        end else begin
            res = CNT_W'(c);
        end
        return res;
    endfunction

endpackage

/* design/mesh_face_index_from_uv_core.sv */
// ----------------------------------------------------------------------------
// mesh_face_index_from_uv_core: face index lookup for one attachment point
// Maps region code and u/v fractions to a face index of the configured shape.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the result side is not stalled;
//   four register stages, each bounded by one narrow multiply or
//   add-and-select (cell multiplies, multiply-add).
// Reset: synchronous, active low; empties all stages and loads register
//   defaults (cylinder, 16 around, 1 high, torus 16x8, sphere 16x8).
// ----------------------------------------------------------------------------
module mesh_face_index_from_uv_core #(
    parameter int FRACTION_BITS = mfi_pkg::FRACTION_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [mfi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mfi_pkg::CFG_W-1:0]        i_cfg_wdata,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mfi_pkg::REGION_W-1:0]     i_region_code,
    input  logic [FRACTION_BITS-1:0]         i_u_frac,
    input  logic [FRACTION_BITS-1:0]         i_v_frac,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mfi_pkg::FACE_W-1:0]       o_face_index
);

    // Effective counts (zero as one, capped) read unshadowed from the registers.
    // The user changes registers only while the pipe is empty; not enforced.
    mfi_pkg::t_cfg_eff cfg;

    // stage 2 -> stage 3 handoff
    logic              s2_valid;
    logic              s2_ready;
    mfi_pkg::t_s2      s2;

    mfi_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Stage 1: clamp u/v to 0.999 and register the request.
    // Stage 2: choose counts by shape and region, form the column and row
    //   cells floor(u*N) and floor(v*M), and decode how they combine.
    //   Sphere poles/bands and capsule hemispheres all reduce to
    //   (row_base + cell) * stride + column.
    mfi_decode #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_region_code (i_region_code),
        .i_u_frac      (i_u_frac),
        .i_v_frac      (i_v_frac),
        .o_s2_valid    (s2_valid),
        .i_s2_ready    (s2_ready),
        .o_s2          (s2)
    );

    // Stage 3: pick row and column terms.
    // Stage 4: one multiply-add into the output register, masked to 18 bits.
    mfi_index u_index (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s2_valid   (s2_valid),
        .o_s2_ready   (s2_ready),
        .i_s2         (s2),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_face_index (o_face_index)
    );

endmodule

/* design/mfi_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mfi_cfg_regs: configuration register file
// Holds shape and segment counts, presents them as effective counts.
// ----------------------------------------------------------------------------
module mfi_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mfi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mfi_pkg::CFG_W-1:0]        i_cfg_wdata,
    output mfi_pkg::t_cfg_eff                o_cfg
);

    logic [mfi_pkg::SHAPE_W-1:0] r_shape;
    logic [mfi_pkg::CFG_W-1:0]   r_around;
    logic [mfi_pkg::CFG_W-1:0]   r_height;
    logic [mfi_pkg::CFG_W-1:0]   r_ring;
    logic [mfi_pkg::CFG_W-1:0]   r_tube;
    logic [mfi_pkg::CFG_W-1:0]   r_longitude;
    logic [mfi_pkg::CFG_W-1:0]   r_latitude;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape     <= mfi_pkg::SHAPE_CYLINDER;
            r_around    <= mfi_pkg::CFG_W'(16);
            r_height    <= mfi_pkg::CFG_W'(1);
            r_ring      <= mfi_pkg::CFG_W'(16);
            r_tube      <= mfi_pkg::CFG_W'(8);
            r_longitude <= mfi_pkg::CFG_W'(16);
            r_latitude  <= mfi_pkg::CFG_W'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mfi_pkg::CFG_SHAPE:     r_shape     <= i_cfg_wdata[mfi_pkg::SHAPE_W-1:0];
                mfi_pkg::CFG_AROUND:    r_around    <= i_cfg_wdata;
                mfi_pkg::CFG_HEIGHT:    r_height    <= i_cfg_wdata;
                mfi_pkg::CFG_RING:      r_ring      <= i_cfg_wdata;
                mfi_pkg::CFG_TUBE:      r_tube      <= i_cfg_wdata;
                mfi_pkg::CFG_LONGITUDE: r_longitude <= i_cfg_wdata;
                mfi_pkg::CFG_LATITUDE:  r_latitude  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.shape     = r_shape;
        o_cfg.around    = mfi_pkg::eff_count(r_around);
        o_cfg.height    = mfi_pkg::eff_count(r_height);
        o_cfg.ring      = mfi_pkg::eff_count(r_ring);
        o_cfg.tube      = mfi_pkg::eff_count(r_tube);
        o_cfg.longitude = mfi_pkg::eff_count(r_longitude);
        o_cfg.latitude  = mfi_pkg::eff_count(r_latitude);
    end

endmodule

/* design/mfi_decode.sv */
// ----------------------------------------------------------------------------
// mfi_decode: input stage and cell stage
// Clamps u/v, picks counts per shape and region, computes floor(u*N), floor(v*M).
// ----------------------------------------------------------------------------
module mfi_decode #(
    parameter int FRACTION_BITS = mfi_pkg::FRACTION_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mfi_pkg::t_cfg_eff              i_cfg,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [mfi_pkg::REGION_W-1:0]   i_region_code,
    input  logic [FRACTION_BITS-1:0]       i_u_frac,
    input  logic [FRACTION_BITS-1:0]       i_v_frac,
    output logic                           o_s2_valid,
    input  logic                           i_s2_ready,
    output mfi_pkg::t_s2                   o_s2
);

    localparam int CNT_W = mfi_pkg::CNT_W;
    localparam int ROW_W = mfi_pkg::ROW_W;
    localparam int PRD_W = FRACTION_BITS + CNT_W;
    // floor(0.999 * 2^FRACTION_BITS)
    localparam logic [FRACTION_BITS-1:0] FracClamp =
        FRACTION_BITS'((64'd999 * (64'd1 << FRACTION_BITS)) / 64'd1000);

    logic                           r_s1_valid;
    logic [mfi_pkg::REGION_W-1:0]   r_s1_region;
    logic [FRACTION_BITS-1:0]       r_s1_u;
    logic [FRACTION_BITS-1:0]       r_s1_v;
    logic                           r_s2_valid;
    mfi_pkg::t_s2                   r_s2;

    logic                           s1_free;
    logic                           s2_free;
    logic [FRACTION_BITS-1:0]       n_s1_u;
    logic [FRACTION_BITS-1:0]       n_s1_v;
    logic [CNT_W-1:0]               cnt_u;
    logic [CNT_W-1:0]               cnt_v;
    logic [CNT_W-1:0]               around_half;
    logic [CNT_W-1:0]               hs;
    logic [PRD_W-1:0]               prod_u;
    logic [PRD_W-1:0]               prod_v;
    mfi_pkg::t_s2                   n_s2;

    assign s2_free    = !r_s2_valid || i_s2_ready;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_ready = s1_free;
    assign o_s2_valid = r_s2_valid;
    assign o_s2       = r_s2;

    assign n_s1_u = (i_u_frac > FracClamp) ? FracClamp : i_u_frac;
    assign n_s1_v = (i_v_frac > FracClamp) ? FracClamp : i_v_frac;

    // capsule hemisphere stacks: max(2, N/2)
    assign around_half = i_cfg.around >> 1;
    assign hs          = (around_half < CNT_W'(2)) ? CNT_W'(2) : around_half;

    always_comb begin
        cnt_u          = i_cfg.around;
        cnt_v          = i_cfg.height;
        n_s2.row_base  = '0;
        n_s2.row_src   = mfi_pkg::ROW_NONE;
        n_s2.col_src   = mfi_pkg::COL_CONST;
        n_s2.col_const = '0;
        n_s2.stride    = i_cfg.around;
        case (i_cfg.shape)
            mfi_pkg::SHAPE_CYLINDER: begin
                if (r_s1_region == mfi_pkg::REGION_TOP) begin
                    n_s2.row_base = ROW_W'(i_cfg.height);
                end else if (r_s1_region == mfi_pkg::REGION_BOTTOM) begin
                    n_s2.row_base  = ROW_W'(i_cfg.height);
                    n_s2.col_const = CNT_W'(1);
                end else begin
                    n_s2.row_src = mfi_pkg::ROW_V;
                    n_s2.col_src = mfi_pkg::COL_U;
                end
            end
            mfi_pkg::SHAPE_CONE: begin
                if (r_s1_region == mfi_pkg::REGION_BASE) begin
                    n_s2.col_const = i_cfg.around;
                end else begin
                    n_s2.col_src = mfi_pkg::COL_U;
                end
            end
            mfi_pkg::SHAPE_TORUS: begin
                cnt_u        = i_cfg.ring;
                cnt_v        = i_cfg.tube;
                n_s2.row_src = mfi_pkg::ROW_U;
                n_s2.col_src = mfi_pkg::COL_V;
                n_s2.stride  = i_cfg.tube;
            end
            mfi_pkg::SHAPE_SPHERE: begin
                // poles and bands collapse to floor(v*T) rows of S faces
                cnt_u        = i_cfg.longitude;
                cnt_v        = i_cfg.latitude;
                n_s2.row_src = mfi_pkg::ROW_V;
                n_s2.col_src = mfi_pkg::COL_U;
                n_s2.stride  = i_cfg.longitude;
            end
            mfi_pkg::SHAPE_CAPSULE: begin
                if (r_s1_region == mfi_pkg::REGION_TOP ||
                    r_s1_region == mfi_pkg::REGION_TOP_CAP) begin
                    cnt_v        = hs;
                    n_s2.row_src = mfi_pkg::ROW_V;
                    n_s2.col_src = mfi_pkg::COL_U;
                end else if (r_s1_region == mfi_pkg::REGION_SIDE) begin
                    n_s2.row_base = ROW_W'(hs);
                    n_s2.row_src  = mfi_pkg::ROW_V;
                    n_s2.col_src  = mfi_pkg::COL_U;
                end else if (r_s1_region == mfi_pkg::REGION_BOTTOM ||
                             r_s1_region == mfi_pkg::REGION_BOTTOM_CAP) begin
                    cnt_v         = hs;
                    n_s2.row_base = ROW_W'(hs) + ROW_W'(i_cfg.height);
                    n_s2.row_src  = mfi_pkg::ROW_V;
                    n_s2.col_src  = mfi_pkg::COL_U;
                end
            end
            default: ;
        endcase
        prod_u      = PRD_W'(r_s1_u) * PRD_W'(cnt_u);
        prod_v      = PRD_W'(r_s1_v) * PRD_W'(cnt_v);
        n_s2.cell_u = prod_u[PRD_W-1:FRACTION_BITS];
        n_s2.cell_v = prod_v[PRD_W-1:FRACTION_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_region <= i_region_code;
            r_s1_u      <= n_s1_u;
            r_s1_v      <= n_s1_v;
        end
        if (s2_free) begin
            r_s2 <= n_s2;
        end
    end

endmodule

/* design/mfi_index.sv */
// ----------------------------------------------------------------------------
// mfi_index: row/column stage and multiply-add output stage
// Forms row and column terms, then face = row * stride + column.
// ----------------------------------------------------------------------------
module mfi_index (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s2_valid,
    output logic                         o_s2_ready,
    input  mfi_pkg::t_s2                 i_s2,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mfi_pkg::FACE_W-1:0]   o_face_index
);

    localparam int CNT_W = mfi_pkg::CNT_W;
    localparam int ROW_W = mfi_pkg::ROW_W;
    localparam int SUM_W = ROW_W + CNT_W + 1;

    logic                          r_s3_valid;
    mfi_pkg::t_s3                  r_s3;
    logic                          r_s4_valid;
    logic [mfi_pkg::FACE_W-1:0]    r_s4_face;

    logic                          s3_free;
    logic                          s4_free;
    logic [ROW_W-1:0]              row_cell;
    mfi_pkg::t_s3                  n_s3;
    logic [SUM_W-1:0]              sum;
    logic [mfi_pkg::FACE_W-1:0]    n_s4_face;

    assign s4_free      = !r_s4_valid || i_out_ready;
    assign s3_free      = !r_s3_valid || s4_free;
    assign o_s2_ready   = s3_free;
    assign o_out_valid  = r_s4_valid;
    assign o_face_index = r_s4_face;

    always_comb begin
        case (i_s2.row_src)
            mfi_pkg::ROW_U: row_cell = ROW_W'(i_s2.cell_u);
            mfi_pkg::ROW_V: row_cell = ROW_W'(i_s2.cell_v);
            default:        row_cell = '0;
        endcase
        case (i_s2.col_src)
            mfi_pkg::COL_U: n_s3.col = i_s2.cell_u;
            mfi_pkg::COL_V: n_s3.col = i_s2.cell_v;
            default:        n_s3.col = i_s2.col_const;
        endcase
        n_s3.row    = i_s2.row_base + row_cell;
        n_s3.stride = i_s2.stride;
    end

    assign sum       = SUM_W'(r_s3.row) * SUM_W'(r_s3.stride) + SUM_W'(r_s3.col);
    assign n_s4_face = mfi_pkg::FACE_W'(sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (s3_free) begin
                r_s3_valid <= i_s2_valid;
            end
            if (s4_free) begin
                r_s4_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            r_s3 <= n_s3;
        end
        if (s4_free) begin
            r_s4_face <= n_s4_face;
        end
    end

endmodule

/* design/mfi_checker.sv */
// ----------------------------------------------------------------------------
// mfi_checker: port-level checks for the face index core
// Reset emptying, result hold, free-flow latency and ready when drained.
// ----------------------------------------------------------------------------
module mfi_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_ready,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic [mfi_pkg::FACE_W-1:0]       o_face_index
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_face_index))
        else $error("stalled result changed");

    // with no pending result nothing blocks the request side
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request stalled with empty output");

    // with the output side ready, an accepted request reaches the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> o_out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind mesh_face_index_from_uv_core mfi_checker u_mfi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_face_index  (o_face_index)
);
